@@ rtl/core/msd_pkg.sv @@
// Shared types, constants and codes for the modulated stereo doubler.
`timescale 1ns / 1ps

package msd_pkg;

  localparam int SAMPLE_BITS      = 24;
  localparam int LINE_DEPTH_DEF   = 2048;
  localparam int SINE_ENTRIES_DEF = 1024;

  localparam int SAMPLE_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SAMPLE_MIN = -(1 << (SAMPLE_BITS - 1));

  localparam int GAIN_W  = 16;
  localparam int STEP_W  = 21;
  localparam int BASE_W  = 19;
  localparam int DEPTH_W = 17;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LEFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_RIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_RIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH   = 3'd6;

  localparam logic [GAIN_W-1:0]  RST_MIX_GAIN   = 16'd11469;
  localparam logic [STEP_W-1:0]  RST_STEP_LEFT  = 21'd31317;
  localparam logic [STEP_W-1:0]  RST_STEP_RIGHT = 21'd41026;
  localparam logic [BASE_W-1:0]  RST_BASE_LEFT  = 19'd233472;
  localparam logic [BASE_W-1:0]  RST_BASE_RIGHT = 19'd331776;
  localparam logic [DEPTH_W-1:0] RST_MOD_DEPTH  = 17'd73728;

  // Shared multiplier: signed 25 x 18
  localparam int MUL_A_W = SAMPLE_BITS + 1;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int U_W    = 17;
  localparam int POLY_W = 18;
  localparam int SINE_W = 16;
  localparam int DLY_W  = 24;
  localparam int SUM_W  = SAMPLE_BITS + 3;

  localparam logic [POLY_W-1:0] POLY_A = 18'd102944;
  localparam logic [POLY_W-1:0] POLY_B = 18'd42334;
  localparam logic [POLY_W-1:0] POLY_C = 18'd5223;
  localparam logic [POLY_W-1:0] POLY_D = 18'd307;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_word_t;

  typedef struct packed {
    logic               enable;
    logic [GAIN_W-1:0]  mix_gain;
    logic [STEP_W-1:0]  phase_step_left;
    logic [STEP_W-1:0]  phase_step_right;
    logic [BASE_W-1:0]  base_delay_left;
    logic [BASE_W-1:0]  base_delay_right;
    logic [DEPTH_W-1:0] mod_depth;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_U,
    OP_UU,
    OP_C,
    OP_B,
    OP_A,
    OP_U3,
    OP_SINE,
    OP_DEPTH,
    OP_DELAY,
    OP_RD0,
    OP_RD1,
    OP_INT,
    OP_TAP,
    OP_GAIN,
    OP_SUM
  } op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_U,
    ST_UU,
    ST_C,
    ST_B,
    ST_A,
    ST_U3,
    ST_SINE,
    ST_DEPTH,
    ST_DELAY,
    ST_RD0,
    ST_RD1,
    ST_INT,
    ST_TAP,
    ST_GAIN,
    ST_SUM,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic out_load;
    logic chan;
    op_t  op;
  } cmd_t;

endpackage

@@ rtl/core/msd_cfg.sv @@
// Configuration register file for the modulated stereo doubler.
`timescale 1ns / 1ps

module msd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [msd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msd_pkg::CFG_DATA_W-1:0] cfg_data,
  output msd_pkg::cfg_t                  cfg
);
  import msd_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable           <= 1'b1;
      cfg_r.mix_gain         <= RST_MIX_GAIN;
      cfg_r.phase_step_left  <= RST_STEP_LEFT;
      cfg_r.phase_step_right <= RST_STEP_RIGHT;
      cfg_r.base_delay_left  <= RST_BASE_LEFT;
      cfg_r.base_delay_right <= RST_BASE_RIGHT;
      cfg_r.mod_depth        <= RST_MOD_DEPTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:     cfg_r.enable           <= cfg_data[0];
        REG_MIX_GAIN:   cfg_r.mix_gain         <= cfg_data[GAIN_W-1:0];
        REG_STEP_LEFT:  cfg_r.phase_step_left  <= cfg_data[STEP_W-1:0];
        REG_STEP_RIGHT: cfg_r.phase_step_right <= cfg_data[STEP_W-1:0];
        REG_BASE_LEFT:  cfg_r.base_delay_left  <= cfg_data[BASE_W-1:0];
        REG_BASE_RIGHT: cfg_r.base_delay_right <= cfg_data[BASE_W-1:0];
        REG_MOD_DEPTH:  cfg_r.mod_depth        <= cfg_data[DEPTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ rtl/core/msd_datapath.sv @@
// Datapath: delay line memory, LFO phases, sine polynomial, taps and mixing.
`timescale 1ns / 1ps

module msd_datapath #(
  parameter int LINE_DEPTH   = msd_pkg::LINE_DEPTH_DEF,
  parameter int SINE_ENTRIES = msd_pkg::SINE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  msd_pkg::cfg_t      cfg,
  input  msd_pkg::cmd_t      cmd,
  input  msd_pkg::in_word_t  in_word,
  output msd_pkg::out_word_t out_word
);
  import msd_pkg::*;

  localparam int LW  = $clog2(LINE_DEPTH);
  localparam int FW  = LW + 1;
  localparam int KW  = $clog2(SINE_ENTRIES);
  localparam int TSH = 18 - KW;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(SAMPLE_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(SAMPLE_MIN);

  logic signed [SAMPLE_BITS-1:0] line_mem [LINE_DEPTH];

  logic [31:0]                   phase_l_r, phase_r_r;
  logic [LW-1:0]                 wp_r;
  logic [FW-1:0]                 fill_r;

  logic signed [SAMPLE_BITS-1:0] in_l_r, in_r_r, res_l_r, res_r_r;
  out_word_t                     out_word_r;
  logic [U_W-1:0]                u_r, u2_r;
  logic [1:0]                    q_r;
  logic signed [SINE_W-1:0]      sine_r;
  logic signed [PROD_W-1:0]      prod_r, acc_r;
  logic [7:0]                    fr_r;
  logic [LW-1:0]                 i0_r, i1_r;
  logic                          v0_r, v1_r;
  logic signed [SAMPLE_BITS-1:0] rdata_r, tap_r;

  logic [31:0]                   phase_sel;
  logic [KW-1:0]                 k;
  logic [U_W-1:0]                t, u_nxt;
  logic [POLY_W-1:0]             hi, hi_inc;
  logic [U_W-1:0]                p_half;
  logic [14:0]                   mag;
  logic signed [SINE_W-1:0]      mag_s, sine_nxt;
  logic signed [PROD_W-1:0]      scaled, gain_sc, tap_sum;
  logic [BASE_W-1:0]             base_sel;
  logic signed [DLY_W-1:0]       d_sum;
  logic [DLY_W-1:0]              d_pos;
  logic [LW-1:0]                 ip, ip1, i0, rd_addr;
  logic                          v0, v1;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic                          mul_en;
  logic signed [PROD_W-1:0]      mul_p;
  logic signed [SAMPLE_BITS-1:0] in_sel, sat_val;
  logic signed [SUM_W-1:0]       sum;

  // Sine phase index and quadrant position
  assign phase_sel = cmd.chan ? phase_r_r : phase_l_r;
  assign k         = phase_sel[31 -: KW];
  assign t         = U_W'(k[KW-3:0]) << TSH;
  assign u_nxt     = k[KW-2] ? (17'd65536 - t) : t;

  assign hi     = prod_r[33:16];
  assign hi_inc = hi + 18'd1;
  assign p_half = hi_inc[POLY_W-1:1];
  assign mag    = (p_half > 17'd32767) ? 15'h7fff : p_half[14:0];
  assign mag_s  = $signed({1'b0, mag});
  assign sine_nxt = q_r[1] ? -mag_s : mag_s;

  // Delay and read addresses
  assign scaled   = prod_r >>> 15;
  assign base_sel = cmd.chan ? cfg.base_delay_right : cfg.base_delay_left;
  assign d_sum    = $signed(DLY_W'(base_sel)) + DLY_W'(scaled);
  assign d_pos    = d_sum[DLY_W-1] ? '0 : d_sum;
  assign ip       = d_pos[8 +: LW];
  assign ip1      = ip + LW'(1);
  assign i0       = wp_r - ip;
  assign v0       = {1'b0, ip} < fill_r;
  assign v1       = {1'b0, ip1} < fill_r;
  assign rd_addr  = (cmd.op == OP_RD1) ? i1_r : i0_r;

  assign tap_sum = acc_r + prod_r;
  assign gain_sc = prod_r >>> 15;
  assign in_sel  = cmd.chan ? in_r_r : in_l_r;
  assign sum     = SUM_W'(in_sel) + SUM_W'(gain_sc);
  assign sat_val = (sum > SAT_HI) ? SAMPLE_BITS'(SAT_HI) :
                   (sum < SAT_LO) ? SAMPLE_BITS'(SAT_LO) : SAMPLE_BITS'(sum);

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b0;
    unique case (cmd.op)
      OP_UU: begin
        mul_a  = $signed(MUL_A_W'(u_r));
        mul_b  = $signed(MUL_B_W'(u_r));
        mul_en = 1'b1;
      end
      OP_C: begin
        mul_a  = $signed(MUL_A_W'(hi));
        mul_b  = $signed(MUL_B_W'(POLY_D));
        mul_en = 1'b1;
      end
      OP_B: begin
        mul_a  = $signed(MUL_A_W'(POLY_C - hi));
        mul_b  = $signed(MUL_B_W'(u2_r));
        mul_en = 1'b1;
      end
      OP_A: begin
        mul_a  = $signed(MUL_A_W'(POLY_B - hi));
        mul_b  = $signed(MUL_B_W'(u2_r));
        mul_en = 1'b1;
      end
      OP_U3: begin
        mul_a  = $signed(MUL_A_W'(POLY_A - hi));
        mul_b  = $signed(MUL_B_W'(u_r));
        mul_en = 1'b1;
      end
      OP_DEPTH: begin
        mul_a  = MUL_A_W'(sine_r);
        mul_b  = $signed(MUL_B_W'(cfg.mod_depth));
        mul_en = 1'b1;
      end
      OP_RD1: begin
        mul_a  = v0_r ? MUL_A_W'(rdata_r) : '0;
        mul_b  = $signed(MUL_B_W'(9'd256 - {1'b0, fr_r}));
        mul_en = 1'b1;
      end
      OP_INT: begin
        mul_a  = v1_r ? MUL_A_W'(rdata_r) : '0;
        mul_b  = $signed(MUL_B_W'(fr_r));
        mul_en = 1'b1;
      end
      OP_GAIN: begin
        mul_a  = MUL_A_W'(tap_r);
        mul_b  = $signed(MUL_B_W'(cfg.mix_gain));
        mul_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      line_mem[wp_r] <= in_word.left_in;
    end
    rdata_r <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_l_r <= '0;
      phase_r_r <= '0;
      wp_r      <= '0;
      fill_r    <= '0;
    end else begin
      if (cmd.start) begin
        phase_l_r <= phase_l_r + 32'(cfg.phase_step_left);
        phase_r_r <= phase_r_r + 32'(cfg.phase_step_right);
        if (fill_r != FW'(LINE_DEPTH)) begin
          fill_r <= fill_r + FW'(1);
        end
      end
      if (cmd.op == OP_SUM && cmd.chan) begin
        wp_r <= wp_r + LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_l_r  <= in_word.left_in;
      in_r_r  <= in_word.right_in;
      res_l_r <= in_word.left_in;
      res_r_r <= in_word.right_in;
    end
    if (mul_en) begin
      prod_r <= mul_p;
    end
    unique case (cmd.op)
      OP_U: begin
        u_r <= u_nxt;
        q_r <= k[KW-1 -: 2];
      end
      OP_C:    u2_r   <= hi[U_W-1:0];
      OP_SINE: sine_r <= sine_nxt;
      OP_DELAY: begin
        fr_r <= d_pos[7:0];
        i0_r <= i0;
        i1_r <= i0 - LW'(1);
        v0_r <= v0;
        v1_r <= v1;
      end
      OP_INT: acc_r <= prod_r;
      OP_TAP: tap_r <= SAMPLE_BITS'(tap_sum >>> 8);
      OP_SUM: begin
        if (cmd.chan) begin
          res_r_r <= sat_val;
        end else begin
          res_l_r <= sat_val;
        end
      end
      default: begin
      end
    endcase
    if (cmd.out_load) begin
      out_word_r.left_out  <= res_l_r;
      out_word_r.right_out <= res_r_r;
    end
  end

  assign out_word = out_word_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(LINE_DEPTH))
    else $error("fill count beyond line depth");

  a_wp_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_SUM && cmd.chan) |=> (wp_r == $past(wp_r) + LW'(1)))
    else $error("write pointer failed to advance after right channel");

endmodule

@@ rtl/core/msd_ctrl.sv @@
// Controller: handshakes and step sequence for one stereo word.
`timescale 1ns / 1ps

module msd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          enable,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output msd_pkg::cmd_t cmd
);
  import msd_pkg::*;

  state_t state_r, state_nxt;
  logic   chan_r, chan_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chan_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chan_r      <= chan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    chan_nxt      = chan_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.op        = OP_NOP;
    cmd.chan      = chan_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          chan_nxt = 1'b0;
          if (enable) begin
            cmd.start = 1'b1;
            state_nxt = ST_U;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_U: begin
        cmd.op    = OP_U;
        state_nxt = ST_UU;
      end
      ST_UU: begin
        cmd.op    = OP_UU;
        state_nxt = ST_C;
      end
      ST_C: begin
        cmd.op    = OP_C;
        state_nxt = ST_B;
      end
      ST_B: begin
        cmd.op    = OP_B;
        state_nxt = ST_A;
      end
      ST_A: begin
        cmd.op    = OP_A;
        state_nxt = ST_U3;
      end
      ST_U3: begin
        cmd.op    = OP_U3;
        state_nxt = ST_SINE;
      end
      ST_SINE: begin
        cmd.op    = OP_SINE;
        state_nxt = ST_DEPTH;
      end
      ST_DEPTH: begin
        cmd.op    = OP_DEPTH;
        state_nxt = ST_DELAY;
      end
      ST_DELAY: begin
        cmd.op    = OP_DELAY;
        state_nxt = ST_RD0;
      end
      ST_RD0: begin
        cmd.op    = OP_RD0;
        state_nxt = ST_RD1;
      end
      ST_RD1: begin
        cmd.op    = OP_RD1;
        state_nxt = ST_INT;
      end
      ST_INT: begin
        cmd.op    = OP_INT;
        state_nxt = ST_TAP;
      end
      ST_TAP: begin
        cmd.op    = OP_TAP;
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.op    = OP_GAIN;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.op = OP_SUM;
        if (chan_r) begin
          state_nxt = ST_FINISH;
        end else begin
          chan_nxt  = 1'b1;
          state_nxt = ST_U;
        end
      end
      ST_FINISH: begin
        // hold until the output slot frees
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("output word overwritten while stalled");

  a_start_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && enable) |=> (state_r == ST_U && !chan_r))
    else $error("enabled word did not start on the left channel");

  a_right_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM && chan_r) |=> (state_r == ST_FINISH))
    else $error("right channel sum not followed by finish");

endmodule

@@ rtl/core/modulated_stereo_doubler.sv @@
// Top level of the modulated stereo doubler.
`timescale 1ns / 1ps

// Stereo chorus doubler: each word accepted with enable set writes the left
// sample into a LINE_DEPTH-entry delay line and adds an interpolated,
// LFO-modulated tap of that line to each channel. With enable set a word
// passes the accept step, fifteen steps per channel sharing the single
// 25x18 multiplier (sine polynomial, depth scaling, two interpolation
// products and the mix gain, one product a cycle) and the output load;
// with enable clear it goes from the accept straight to the output load.
// The next word is taken while a result waits on a stalled output. Entries
// not yet written since reset read as zero through a fill count, so there
// is no clearing pass. LINE_DEPTH and SINE_ENTRIES must be powers of two.
module modulated_stereo_doubler #(
  parameter int LINE_DEPTH   = msd_pkg::LINE_DEPTH_DEF,
  parameter int SINE_ENTRIES = msd_pkg::SINE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  msd_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output msd_pkg::out_word_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [msd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import msd_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  msd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  msd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (cfg.enable),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  msd_datapath #(
    .LINE_DEPTH   (LINE_DEPTH),
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .cmd      (cmd),
    .in_word  (in_data),
    .out_word (out_data)
  );

endmodule
